@@ sv/codepoint_to_glyph_lookup_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the code point to glyph lookup.
// Each check is clocked on clk_i and is quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CODEPOINT_TO_GLYPH_LOOKUP_DEFINES_SVH
`define CODEPOINT_TO_GLYPH_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF
`define CGLK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CGLK_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);
`else
`define CGLK_ASSERT(lbl, prop, msg)
`define CGLK_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

@@ sv/cglk_pkg.sv @@
// ----------------------------------------------------------------------------
// cglk_pkg
// Constants, microcode format and the visual alias table of the glyph lookup.
// ----------------------------------------------------------------------------
package cglk_pkg;

  localparam int CPW = 21;

  typedef logic [CPW-1:0] cp_t;

  localparam cp_t CP_ASCII_LO   = 21'h00020;
  localparam cp_t CP_ASCII_END  = 21'h0007F;
  localparam cp_t CP_NBSP       = 21'h000A0;
  localparam cp_t CP_FIGURE_SP  = 21'h02007;
  localparam cp_t CP_THIN_SP    = 21'h02009;
  localparam cp_t CP_ZW_SP      = 21'h0200B;
  localparam cp_t CP_NARROW_SP  = 21'h0202F;
  localparam cp_t CP_BOM        = 21'h0FEFF;
  localparam cp_t CP_BOX_LO     = 21'h02500;
  localparam cp_t CP_BOX_HI     = 21'h0257F;
  localparam cp_t CP_BOX_VERT   = 21'h02502;
  localparam cp_t CP_BOX_HORIZ  = 21'h02500;
  localparam cp_t CP_BLOCK_LO   = 21'h02580;
  localparam cp_t CP_BLOCK_HI   = 21'h0259F;
  localparam cp_t CP_FULL_BLOCK = 21'h02588;

  localparam logic [15:0] SPACE_GLYPH = 16'd0;
  localparam logic [15:0] QMARK_GLYPH = 16'd31;

  // Microcode step addresses.
  typedef logic [3:0] step_t;

  localparam step_t STEP_CLASSIFY = 4'd0;
  localparam step_t STEP_PROBE_1  = 4'd1;
  localparam step_t STEP_CMP_1    = 4'd2;
  localparam step_t STEP_ALIAS    = 4'd3;
  localparam step_t STEP_PROBE_2  = 4'd4;
  localparam step_t STEP_CMP_2    = 4'd5;
  localparam step_t STEP_RANGE    = 4'd6;
  localparam step_t STEP_PROBE_3  = 4'd7;
  localparam step_t STEP_CMP_3    = 4'd8;
  localparam step_t STEP_QMARK    = 4'd9;

  typedef enum logic [2:0] {
    ACT_CLASSIFY,
    ACT_PROBE,
    ACT_COMPARE,
    ACT_ALIAS,
    ACT_RANGE,
    ACT_QMARK
  } act_e;

  // One control word: the action, the step taken on the normal path and the
  // step taken on the alternate path (miss, mismatch, no alias, no range).
  typedef struct packed {
    act_e  act;
    step_t next;
    step_t alt;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{act: ACT_QMARK, next: STEP_CLASSIFY, alt: STEP_CLASSIFY};
    unique case (s)
      STEP_CLASSIFY: w = '{act: ACT_CLASSIFY, next: STEP_PROBE_1, alt: STEP_CLASSIFY};
      STEP_PROBE_1:  w = '{act: ACT_PROBE,    next: STEP_CMP_1,   alt: STEP_ALIAS};
      STEP_CMP_1:    w = '{act: ACT_COMPARE,  next: STEP_CLASSIFY, alt: STEP_PROBE_1};
      STEP_ALIAS:    w = '{act: ACT_ALIAS,    next: STEP_PROBE_2, alt: STEP_RANGE};
      STEP_PROBE_2:  w = '{act: ACT_PROBE,    next: STEP_CMP_2,   alt: STEP_RANGE};
      STEP_CMP_2:    w = '{act: ACT_COMPARE,  next: STEP_CLASSIFY, alt: STEP_PROBE_2};
      STEP_RANGE:    w = '{act: ACT_RANGE,    next: STEP_PROBE_3, alt: STEP_QMARK};
      STEP_PROBE_3:  w = '{act: ACT_PROBE,    next: STEP_CMP_3,   alt: STEP_QMARK};
      STEP_CMP_3:    w = '{act: ACT_COMPARE,  next: STEP_CLASSIFY, alt: STEP_PROBE_3};
      default:       w = '{act: ACT_QMARK,    next: STEP_CLASSIFY, alt: STEP_CLASSIFY};
    endcase
    return w;
  endfunction

  function automatic logic is_special_space(cp_t cp);
    return (cp == CP_NBSP) || (cp == CP_NARROW_SP) || (cp == CP_FIGURE_SP) ||
           (cp == CP_THIN_SP) || (cp == CP_ZW_SP) || (cp == CP_BOM);
  endfunction

  // Visual stand-ins for symbols the font usually lacks; zero means none.
  function automatic cp_t alias_of(cp_t cp);
    cp_t a;
    case (cp)
      21'h023F4: a = 21'h025C0;
      21'h023F5: a = 21'h025B6;
      21'h023F6: a = 21'h025B2;
      21'h023F7: a = 21'h025BC;
      21'h023F8: a = 21'h02016;
      21'h023F9: a = 21'h025A0;
      21'h023FA: a = 21'h025CF;
      21'h023EF: a = 21'h025B6;
      21'h023ED: a = 21'h025B6;
      21'h023EE: a = 21'h025C0;
      21'h02705: a = 21'h02714;
      21'h0274C: a = 21'h02716;
      21'h0274E: a = 21'h02716;
      21'h026D4: a = 21'h02718;
      21'h026A0: a = 21'h025B3;
      21'h026A1: a = 21'h021AF;
      21'h02728: a = 21'h02605;
      21'h1F534: a = 21'h025CF;
      21'h1F535: a = 21'h025CF;
      21'h1F7E0: a = 21'h025CF;
      21'h1F7E1: a = 21'h025CF;
      21'h1F7E2: a = 21'h025CF;
      21'h1F7E3: a = 21'h025CF;
      21'h1F7E4: a = 21'h025CF;
      21'h026AA: a = 21'h025CB;
      21'h026AB: a = 21'h025CF;
      21'h1F7E5: a = 21'h025A0;
      21'h1F7E6: a = 21'h025A0;
      21'h1F7E7: a = 21'h025A0;
      21'h1F7E8: a = 21'h025A0;
      21'h1F7E9: a = 21'h025A0;
      21'h1F7EA: a = 21'h025A0;
      21'h1F7EB: a = 21'h025A0;
      21'h02B1B: a = 21'h025A0;
      21'h02B1C: a = 21'h025A1;
      21'h1F4A1: a = 21'h0263C;
      21'h1F680: a = 21'h02197;
      21'h1F4E6: a = 21'h025A3;
      21'h1F527: a = 21'h02699;
      21'h1F4DD: a = 21'h0270D;
      21'h1F511: a = 21'h021B3;
      21'h1F4DA: a = 21'h02261;
      21'h1F50D: a = 21'h02315;
      21'h1F50E: a = 21'h02315;
      21'h1F4CC: a = 21'h02691;
      21'h1F4CD: a = 21'h02691;
      21'h0231B: a = 21'h029D6;
      21'h023F3: a = 21'h029D6;
      21'h1F4C1: a = 21'h0F115;
      21'h1F4C2: a = 21'h0F115;
      21'h1F4C4: a = 21'h0F15B;
      21'h1F389: a = 21'h02605;
      default:   a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ sv/cglk_ram.sv @@
// ----------------------------------------------------------------------------
// cglk_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cglk_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/codepoint_to_glyph_lookup.sv @@
// ----------------------------------------------------------------------------
// codepoint_to_glyph_lookup
// A load beat is written into the table RAM when it is taken, and loads may
// follow every cycle while busy_o is low. A lookup that resolves by class
// (ASCII, spaces) ends in its classify step. Otherwise it runs a classify step,
// a search of probe and compare steps that hits or misses after at most
// log2(len)+1 probes, an alias step after a first miss, and a range step and a
// question mark step where reached. No stand-in source lies in the box or block
// ranges, so at most two searches run. done_o pulses in the first cycle in which
// busy_o reads low, and the next beat may be taken at the edge that ends it; the
// receiver cannot stall. The microcode step sequencer and the single read port
// of the table RAM set the pace of a lookup.
// Reset clears the sequencer, table_len and the result strobe; the table itself
// holds no reset and must be loaded before it is searched.
// ----------------------------------------------------------------------------
`include "codepoint_to_glyph_lookup_defines.svh"

module codepoint_to_glyph_lookup #(
  parameter int TABLE_DEPTH = 1024,
  parameter int GLYPH_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [9:0]  slot_i,
  input  logic [20:0] codepoint_i,
  input  logic [15:0] glyph_i,
  // Result channel
  output logic        done_o,
  output logic [15:0] glyph_index_o,
  // Configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  import cglk_pkg::*;

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW    = AW + 1;
  localparam int WIDTH = CPW + GLYPH_BITS;

  localparam logic REG_TABLE_LEN = 1'b0;

  // Registers
  logic [10:0]     table_len_q;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [15:0]     result_q, result_d;
  step_t           pc_q, pc_d;
  cp_t             cp_q;
  cp_t             tgt_q, tgt_d;
  logic [LW-1:0]   lo_q, lo_d;
  logic [LW-1:0]   hi_q, hi_d;
  logic [AW-1:0]   mid_q, mid_d;

  // Datapath signals
  ctrl_t           ctrl;
  logic            lookup_accept;
  logic            load_we;
  logic            rd_en;
  logic [LW-1:0]   len_sat;
  logic [LW:0]     probe_sum;
  logic [AW-1:0]   probe_mid;
  logic [WIDTH-1:0] rd_data;
  cp_t             entry_cp;
  logic [GLYPH_BITS-1:0] entry_glyph;
  cp_t             alias_cp;
  logic            cfg_write;

  assign lookup_accept = start_i && !busy_q && kind_i;
  assign load_we       = start_i && !busy_q && !kind_i && (32'(slot_i) < TABLE_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign pready_o  = 1'b1;
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_len_q <= '0;
    end else if (cfg_write && (paddr_i[2] == REG_TABLE_LEN)) begin
      table_len_q <= pwdata_i[10:0];
    end
  end

  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == REG_TABLE_LEN) begin
      prdata_o = 32'(table_len_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Table memory: code point in the upper bits, glyph number in the lower bits
  // ---------------------------------------------------------------------------
  cglk_ram #(
    .WIDTH (WIDTH),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(slot_i)),
    .wdata_i ({codepoint_i, glyph_i[GLYPH_BITS-1:0]}),
    .re_i    (rd_en),
    .raddr_i (probe_mid),
    .rdata_o (rd_data)
  );

  assign entry_cp    = rd_data[WIDTH-1:GLYPH_BITS];
  assign entry_glyph = rd_data[GLYPH_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Search arithmetic. The window is [lo, hi) with hi exclusive, so the probe
  // is floor((lo + hi - 1) / 2), the same midpoint as an inclusive search.
  // ---------------------------------------------------------------------------
  assign len_sat   = (32'(table_len_q) > TABLE_DEPTH) ? LW'(TABLE_DEPTH) : LW'(table_len_q);
  assign probe_sum = (LW+1)'(lo_q) + (LW+1)'(hi_q) - (LW+1)'(1);
  assign probe_mid = probe_sum[AW:1];
  assign alias_cp  = alias_of(cp_q);

  // ---------------------------------------------------------------------------
  // Microcoded sequencer
  // ---------------------------------------------------------------------------
  assign ctrl = ucode(pc_q);

  always_comb begin
    pc_d     = pc_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    result_d = result_q;
    tgt_d    = tgt_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    rd_en    = 1'b0;

    if (lookup_accept) begin
      busy_d = 1'b1;
      pc_d   = STEP_CLASSIFY;
    end else if (busy_q) begin
      unique case (ctrl.act)
        ACT_CLASSIFY: begin
          if ((cp_q >= CP_ASCII_LO) && (cp_q < CP_ASCII_END)) begin
            result_d = 16'(cp_q - CP_ASCII_LO);
            done_d   = 1'b1;
            busy_d   = 1'b0;
            pc_d     = STEP_CLASSIFY;
          end else if (is_special_space(cp_q)) begin
            result_d = SPACE_GLYPH;
            done_d   = 1'b1;
            busy_d   = 1'b0;
            pc_d     = STEP_CLASSIFY;
          end else begin
            tgt_d = cp_q;
            lo_d  = '0;
            hi_d  = len_sat;
            pc_d  = ctrl.next;
          end
        end
        ACT_PROBE: begin
          if (lo_q < hi_q) begin
            mid_d = probe_mid;
            rd_en = 1'b1;
            pc_d  = ctrl.next;
          end else begin
            pc_d = ctrl.alt;
          end
        end
        ACT_COMPARE: begin
          if (entry_cp == tgt_q) begin
            result_d = 16'(entry_glyph);
            done_d   = 1'b1;
            busy_d   = 1'b0;
            pc_d     = ctrl.next;
          end else begin
            if (entry_cp < tgt_q) begin
              lo_d = LW'(mid_q) + LW'(1);
            end else begin
              hi_d = LW'(mid_q);
            end
            pc_d = ctrl.alt;
          end
        end
        ACT_ALIAS: begin
          if ((alias_cp != '0) && (alias_cp != cp_q)) begin
            tgt_d = alias_cp;
            lo_d  = '0;
            hi_d  = len_sat;
            pc_d  = ctrl.next;
          end else begin
            pc_d = ctrl.alt;
          end
        end
        ACT_RANGE: begin
          // Box drawing falls back to a straight line, block elements to the
          // full block.
          if ((cp_q >= CP_BOX_LO) && (cp_q <= CP_BOX_HI)) begin
            tgt_d = cp_q[0] ? CP_BOX_VERT : CP_BOX_HORIZ;
            lo_d  = '0;
            hi_d  = len_sat;
            pc_d  = ctrl.next;
          end else if ((cp_q >= CP_BLOCK_LO) && (cp_q <= CP_BLOCK_HI)) begin
            tgt_d = CP_FULL_BLOCK;
            lo_d  = '0;
            hi_d  = len_sat;
            pc_d  = ctrl.next;
          end else begin
            pc_d = ctrl.alt;
          end
        end
        ACT_QMARK: begin
          result_d = QMARK_GLYPH;
          done_d   = 1'b1;
          busy_d   = 1'b0;
          pc_d     = STEP_CLASSIFY;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pc_q   <= STEP_CLASSIFY;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      pc_q   <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_accept) begin
      cp_q <= codepoint_i;
    end
    result_q <= result_d;
    tgt_q    <= tgt_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
  end

  assign busy_o        = busy_q;
  assign done_o        = done_q;
  assign glyph_index_o = result_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CGLK_ASSERT(a_done_ends_item, done_o |-> ($past(busy_o) && !busy_o), "result beat without a lookup in flight")
  `CGLK_ASSERT_NEXT(a_load_no_busy, start_i && !busy_o && !kind_i, !busy_o && !done_o, "load beat started a lookup")
  `CGLK_ASSERT_NEXT(a_lookup_busy, start_i && !busy_o && kind_i, busy_o && !done_o && (pc_q == STEP_CLASSIFY), "lookup beat did not enter the sequencer")

endmodule

@@ tb/sv/tb_codepoint_to_glyph_lookup.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_codepoint_to_glyph_lookup
// Self-checking bench for the code point to glyph lookup. Loads mostly sorted
// tables of assorted sizes, programs table_len over the APB port while the
// block is idle, and streams lookups that hit the table, miss it, go through
// the visual stand-ins or the box and block substitutes. A predictor kept in
// step with each accepted beat produces the expected glyph index per lookup.
// ----------------------------------------------------------------------------
module tb_codepoint_to_glyph_lookup;
  import cglk_pkg::*;

  localparam int          DEPTH          = 1024;
  localparam int          MAX_CP         = 'h10FFFF;
  localparam int          MAX_GAP        = 13;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          DRAIN_CYCLES   = 80;
  localparam int          ITEM_TARGET    = 1624;
  localparam logic        KIND_LOAD      = 1'b0;
  localparam logic        KIND_LOOKUP    = 1'b1;
  localparam logic [2:0]  ADDR_TABLE_LEN = 3'd0;
  localparam logic [10:0] TABLE_LEN_MAX  = 11'h7FF;

  // Stand-in pairs, looked-up code point in the upper half.
  localparam int N_STAND_INS = 52;
  localparam logic [0:N_STAND_INS-1][41:0] STAND_INS = {
    {21'h023F4, 21'h025C0}, {21'h023F5, 21'h025B6}, {21'h023F6, 21'h025B2},
    {21'h023F7, 21'h025BC}, {21'h023F8, 21'h02016}, {21'h023F9, 21'h025A0},
    {21'h023FA, 21'h025CF}, {21'h023EF, 21'h025B6}, {21'h023ED, 21'h025B6},
    {21'h023EE, 21'h025C0}, {21'h02705, 21'h02714}, {21'h0274C, 21'h02716},
    {21'h0274E, 21'h02716}, {21'h026D4, 21'h02718}, {21'h026A0, 21'h025B3},
    {21'h026A1, 21'h021AF}, {21'h02728, 21'h02605}, {21'h1F534, 21'h025CF},
    {21'h1F535, 21'h025CF}, {21'h1F7E0, 21'h025CF}, {21'h1F7E1, 21'h025CF},
    {21'h1F7E2, 21'h025CF}, {21'h1F7E3, 21'h025CF}, {21'h1F7E4, 21'h025CF},
    {21'h026AA, 21'h025CB}, {21'h026AB, 21'h025CF}, {21'h1F7E5, 21'h025A0},
    {21'h1F7E6, 21'h025A0}, {21'h1F7E7, 21'h025A0}, {21'h1F7E8, 21'h025A0},
    {21'h1F7E9, 21'h025A0}, {21'h1F7EA, 21'h025A0}, {21'h1F7EB, 21'h025A0},
    {21'h02B1B, 21'h025A0}, {21'h02B1C, 21'h025A1}, {21'h1F4A1, 21'h0263C},
    {21'h1F680, 21'h02197}, {21'h1F4E6, 21'h025A3}, {21'h1F527, 21'h02699},
    {21'h1F4DD, 21'h0270D}, {21'h1F511, 21'h021B3}, {21'h1F4DA, 21'h02261},
    {21'h1F50D, 21'h02315}, {21'h1F50E, 21'h02315}, {21'h1F4CC, 21'h02691},
    {21'h1F4CD, 21'h02691}, {21'h0231B, 21'h029D6}, {21'h023F3, 21'h029D6},
    {21'h1F4C1, 21'h0F115}, {21'h1F4C2, 21'h0F115}, {21'h1F4C4, 21'h0F15B},
    {21'h1F389, 21'h02605}
  };

  // Code points worth having in a table, ascending: substitutes, stand-in
  // targets, one stand-in source and one box character.
  localparam int N_HOT = 32;
  localparam logic [0:N_HOT-1][20:0] HOT_CPS = {
    21'h02016, 21'h02197, 21'h021AF, 21'h021B3, 21'h02261, 21'h02315, 21'h023F4,
    21'h02500, 21'h02502, 21'h02510, 21'h02588, 21'h025A0, 21'h025A1, 21'h025A3,
    21'h025B2, 21'h025B3, 21'h025B6, 21'h025BC, 21'h025C0, 21'h025CB, 21'h025CF,
    21'h02605, 21'h0263C, 21'h02691, 21'h02699, 21'h0270D, 21'h02714, 21'h02716,
    21'h02718, 21'h029D6, 21'h0F115, 21'h0F15B
  };

  localparam logic [0:5][20:0] SPACE_CPS = {
    CP_NBSP, CP_FIGURE_SP, CP_THIN_SP, CP_ZW_SP, CP_NARROW_SP, CP_BOM
  };

  localparam logic [0:11][20:0] EMPTY_TABLE_PROBES = {
    21'h00020, 21'h0007E, 21'h0001F, 21'h0007F, 21'h00000, 21'h000A0,
    21'h02009, 21'h0FEFF, 21'h0257F, 21'h02580, 21'h023F4, 21'h10FFFF
  };

  localparam logic [0:6][20:0] SMALL_TABLE_PROBES = {
    21'h02500, 21'h0257F, 21'h02574, 21'h0259F, 21'h023EE, 21'h1F4C2, 21'h02007
  };

  typedef struct {
    logic        kind;
    logic [9:0]  slot;
    cp_t         cp;
    logic [15:0] glyph;
    int          gap;
  } cmd_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start_i       = 1'b0;
  logic        kind_i        = 1'b0;
  logic [9:0]  slot_i        = '0;
  logic [20:0] codepoint_i   = '0;
  logic [15:0] glyph_i       = '0;
  logic        psel_i        = 1'b0;
  logic        penable_i     = 1'b0;
  logic        pwrite_i      = 1'b0;
  logic [2:0]  paddr_i       = '0;
  logic [31:0] pwdata_i      = '0;
  logic        busy_o;
  logic        done_o;
  logic [15:0] glyph_index_o;
  logic [31:0] prdata_o;
  logic        pready_o;

  codepoint_to_glyph_lookup uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .slot_i        (slot_i),
    .codepoint_i   (codepoint_i),
    .glyph_i       (glyph_i),
    .done_o        (done_o),
    .glyph_index_o (glyph_index_o),
    .psel_i        (psel_i),
    .penable_i     (penable_i),
    .pwrite_i      (pwrite_i),
    .paddr_i       (paddr_i),
    .pwdata_i      (pwdata_i),
    .prdata_o      (prdata_o),
    .pready_o      (pready_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Predictor state: a copy of the glyph table and of table_len.
  cp_t         lut_cp    [DEPTH];
  logic [15:0] lut_glyph [DEPTH];
  logic [10:0] cur_table_len = '0;

  cmd_t        pending_cmds[$];
  logic [15:0] expected_glyphs[$];
  bit          slot_written [DEPTH];
  cp_t         phase_cp     [DEPTH];
  logic [15:0] phase_glyph  [DEPTH];
  int          slot_order   [DEPTH];

  bit  beat_taken;
  bit  gap_armed;
  bit  quiet_run;
  int  gap_left;
  int  cmds_queued;
  int  lookups_done;
  int  loads_done;
  int  results_checked;
  int  config_writes;
  int  mismatches;
  int  stall_cycles;
  cmd_t next_cmd;

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %0s: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  function automatic bit table_hit(cp_t cp, output logic [15:0] g);
    int lo, hi, mid, n;
    g  = '0;
    n  = (cur_table_len > 11'(DEPTH)) ? DEPTH : int'(cur_table_len);
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (lut_cp[mid] == cp) begin
        g = lut_glyph[mid];
        return 1'b1;
      end
      if (lut_cp[mid] < cp) lo = mid + 1;
      else hi = mid - 1;
    end
    return 1'b0;
  endfunction

  function automatic cp_t stand_in_for(cp_t cp);
    for (int i = 0; i < N_STAND_INS; i++) begin
      if (STAND_INS[i][41:21] == cp) return STAND_INS[i][20:0];
    end
    return '0;
  endfunction

  function automatic logic [15:0] predict_glyph(cp_t cp);
    logic [15:0] g;
    cp_t         sub;
    sub = stand_in_for(cp);
    if (cp >= CP_ASCII_LO && cp < CP_ASCII_END) return 16'(cp - CP_ASCII_LO);
    if (cp inside {CP_NBSP, CP_FIGURE_SP, CP_THIN_SP, CP_ZW_SP, CP_NARROW_SP, CP_BOM}) begin
      return SPACE_GLYPH;
    end
    if (table_hit(cp, g)) return g;
    if (sub != '0 && sub != cp && table_hit(sub, g)) return g;
    // A missing box or block substitute ends at the question mark.
    if (cp >= CP_BOX_LO && cp <= CP_BOX_HI) begin
      if (table_hit(cp[0] ? CP_BOX_VERT : CP_BOX_HORIZ, g)) return g;
      return QMARK_GLYPH;
    end
    if (cp >= CP_BLOCK_LO && cp <= CP_BLOCK_HI) begin
      if (table_hit(CP_FULL_BLOCK, g)) return g;
      return QMARK_GLYPH;
    end
    return QMARK_GLYPH;
  endfunction

  // Command beats: taken at the rising edge, predicted right there.
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      beat_taken = 1'b1;
      if (kind_i == KIND_LOAD) begin
        lut_cp[slot_i]    = codepoint_i;
        lut_glyph[slot_i] = glyph_i;
        loads_done++;
      end else begin
        expected_glyphs.push_back(predict_glyph(codepoint_i));
        lookups_done++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || beat_taken) begin
      beat_taken = 1'b0;
      if (pending_cmds.size() == 0) begin
        start_i <= 1'b0;
      end else begin
        if (!gap_armed) begin
          gap_left  = pending_cmds[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else begin
          next_cmd    = pending_cmds.pop_front();
          gap_armed   = 1'b0;
          kind_i      <= next_cmd.kind;
          slot_i      <= next_cmd.slot;
          codepoint_i <= next_cmd.cp;
          glyph_i     <= next_cmd.glyph;
          start_i     <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni && done_o) begin
      results_checked++;
      if (expected_glyphs.size() == 0) begin
        flag_mismatch("glyph_index with no lookup pending", '0, 32'(glyph_index_o));
      end else begin
        want = expected_glyphs.pop_front();
        if (glyph_index_o !== want) begin
          flag_mismatch("glyph_index", 32'(want), 32'(glyph_index_o));
        end
      end
    end
  end

  // Counts cycles in which no beat of any kind moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (psel_i && penable_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [15:0] rand_glyph();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 'hFFFF));
    endcase
  endfunction

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < DEPTH && slot_written[n]) n++;
    return n;
  endfunction

  task automatic push_load(int slot, cp_t cp, logic [15:0] glyph);
    cmd_t c;
    c.kind  = KIND_LOAD;
    c.slot  = 10'(slot);
    c.cp    = cp;
    c.glyph = glyph;
    c.gap   = quiet_run ? 0 : $urandom_range(0, MAX_GAP);
    slot_written[slot] = 1'b1;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic push_lookup(cp_t cp);
    cmd_t c;
    c.kind  = KIND_LOOKUP;
    c.slot  = 10'($urandom_range(0, DEPTH - 1));
    c.cp    = cp;
    c.glyph = 16'($urandom_range(0, 'hFFFF));
    c.gap   = quiet_run ? 0 : $urandom_range(0, MAX_GAP);
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic push_noise_load();
    push_load($urandom_range(0, DEPTH - 1), cp_t'($urandom_range(0, MAX_CP)), rand_glyph());
  endtask

  // Picks a lookup from the first n table entries, a special class or at random.
  function automatic cp_t pick_lookup_cp(int n);
    int          r;
    logic [41:0] pair;
    r = $urandom_range(0, 99);
    if (r < 40 && n > 0) return phase_cp[$urandom_range(0, n - 1)];
    if (r < 50) begin
      pair = STAND_INS[$urandom_range(0, N_STAND_INS - 1)];
      return pair[41:21];
    end
    if (r < 65) return cp_t'($urandom_range('h24FF, 'h25A0));
    if (r < 75) return cp_t'($urandom_range(0, 'h9F));
    if (r < 80) return SPACE_CPS[$urandom_range(0, 5)];
    return cp_t'($urandom_range(0, MAX_CP));
  endfunction

  // Returns once the block is idle and nothing is queued or expected.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start_i || busy_o || expected_glyphs.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_table_len(logic [10:0] value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel_i    = 1'b1;
    penable_i = 1'b0;
    pwrite_i  = 1'b1;
    paddr_i   = ADDR_TABLE_LEN;
    pwdata_i  = 32'(value);
    @(negedge clk_i);
    penable_i = 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    cur_table_len = value;
    config_writes++;
    // Read the register straight back.
    @(negedge clk_i);
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
    @(negedge clk_i);
    penable_i = 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    readback = prdata_o;
    @(negedge clk_i);
    psel_i    = 1'b0;
    penable_i = 1'b0;
    if (readback[10:0] !== value) flag_mismatch("table_len read back", 32'(value), readback);
  endtask

  // Builds a table of n entries, mostly ascending, loads it in shuffled slot
  // order, sets table_len and sends lookups with the odd stray load mixed in.
  task automatic run_table_phase(int n, int n_look);
    int cur, left, room, step, k, j, tmp, tlen;
    cp_t swap_cp;
    cur = ($urandom_range(0, 3) == 0) ? -1 : int'($urandom_range('h1F00, 'h24F0));
    for (int i = 0; i < n; i++) begin
      left = n - i;
      room = (MAX_CP - cur - left) / left;
      k = 0;
      while (k < N_HOT && int'(HOT_CPS[k]) <= cur) k++;
      while (k < N_HOT - 1 && $urandom_range(0, 1) == 1) k++;
      case ($urandom_range(0, 3))
        0:       step = 1 + $urandom_range(0, (room < 2) ? room : 2);
        1:       step = (k < N_HOT) ? int'(HOT_CPS[k]) - cur : 1;
        2:       step = 1 + $urandom_range(0, (room < 'h1FF) ? room : 'h1FF);
        default: step = 1 + $urandom_range(0, room);
      endcase
      cur = cur + step;
      phase_cp[i]    = cp_t'(cur);
      phase_glyph[i] = rand_glyph();
    end
    // Now and then the table is left out of order.
    if (n >= 2 && $urandom_range(0, 7) == 0) begin
      j = $urandom_range(0, n - 1);
      k = $urandom_range(0, n - 1);
      swap_cp     = phase_cp[j];
      phase_cp[j] = phase_cp[k];
      phase_cp[k] = swap_cp;
    end
    for (int i = 0; i < n; i++) slot_order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp           = slot_order[i];
      slot_order[i] = slot_order[j];
      slot_order[j] = tmp;
    end
    // A stale entry that the real load overwrites later in the phase.
    if (n > 0 && $urandom_range(0, 3) == 0) begin
      push_load($urandom_range(0, n - 1), cp_t'($urandom_range(0, MAX_CP)), rand_glyph());
    end
    for (int i = 0; i < n; i++) begin
      push_load(slot_order[i], phase_cp[slot_order[i]], phase_glyph[slot_order[i]]);
    end
    wait_idle();
    tlen = n;
    if ($urandom_range(0, 5) == 0) tlen = $urandom_range(0, written_prefix());
    write_table_len(11'(tlen));
    for (int i = 0; i < n_look; i++) begin
      if ($urandom_range(0, 9) == 0) push_noise_load();
      push_lookup(pick_lookup_cp((tlen < n) ? tlen : n));
    end
  endtask

  initial begin
    int phase_no;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table first: only the class checks and the question mark apply.
    write_table_len(11'd0);
    for (int i = 0; i < 12; i++) push_lookup(EMPTY_TABLE_PROBES[i]);
    push_load(0, CP_BOX_HORIZ,  16'h0000);
    push_load(1, CP_BOX_VERT,   16'hFFFF);
    push_load(2, CP_FULL_BLOCK, 16'h1234);
    push_load(3, 21'h025C0,     16'h00C5);
    push_load(4, 21'h0F115,     16'h8001);
    wait_idle();
    write_table_len(11'd5);
    for (int i = 0; i < 7; i++) push_lookup(SMALL_TABLE_PROBES[i]);

    phase_no = 0;
    while (cmds_queued < ITEM_TARGET) begin
      quiet_run = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) begin
        // Full depth, then a table_len beyond the depth.
        run_table_phase(DEPTH, 80);
        wait_idle();
        write_table_len(TABLE_LEN_MAX);
        for (int i = 0; i < 80; i++) push_lookup(pick_lookup_cp(DEPTH));
      end else begin
        run_table_phase(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 48),
                        $urandom_range(16, 48));
      end
      phase_no++;
    end

    while (pending_cmds.size() != 0 || start_i || expected_glyphs.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d lookups and %0d table loads over %0d table_len writes.",
             lookups_done, loads_done, config_writes);
    $display("Checked %0d glyph results; %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
